[rtl/nndr_pkg.sv]
// Package for the nearest neighbour distance ranker.
// Holds the beat structs, the operation and status codes and the sequencer states.
// No dependencies.
package nndr_pkg;

	localparam int MAX_ELEMENTS_DEF = 4096;
	localparam int MAX_ITEMS_DEF = 8192;
	localparam int DIST_W = 42;
	localparam int ITEM_W = 13;
	localparam int VAL_W = 16;
	localparam int IDX_W = 12;
	localparam int LEN_W = 13;
	localparam int CFG_IDX_W = 1;
	localparam logic [LEN_W-1:0] VECTOR_LENGTH_RESET = 13'd4096;

	localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_NEAREST = 1'd1;

	typedef enum logic [1:0] {
		OP_QUERY = 2'd0,
		OP_DATABASE = 2'd1,
		OP_READ = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_RANK_RANGE = 2'd1,
		ST_FULL = 2'd2,
		ST_UNUSED = 2'd3
	} status_t;

	localparam logic KIND_ITEM = 1'b0;
	localparam logic KIND_RANK = 1'b1;

	typedef struct packed {
		logic [1:0] operation;
		logic [VAL_W-1:0] element_value;
		logic [IDX_W-1:0] element_index;
		logic [ITEM_W-1:0] rank_position;
	} in_beat_t;

	typedef struct packed {
		logic result_kind;
		logic [ITEM_W-1:0] item_number;
		logic [DIST_W-1:0] squared_distance;
		logic [1:0] status;
	} out_beat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_QREAD,
		S_MAC,
		S_SCAN,
		S_SHIFT,
		S_PLACE,
		S_RREAD,
		S_RDONE
	} state_t;

	// Control from the sequencer to the table memory.
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic wr_sel_new;
	} tbl_ctl_t;

endpackage

[rtl/nndr_mac.sv]
// Shared difference-square-accumulate unit with saturation.
// Depends on nndr_pkg.
module nndr_mac
	import nndr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic clr,
	input  logic step,
	input  logic [VAL_W-1:0] a,
	input  logic [VAL_W-1:0] b,
	output logic [DIST_W-1:0] acc_next
);

	logic [DIST_W-1:0] acc_q;
	logic [VAL_W-1:0] diff;
	logic [2*VAL_W-1:0] sq;
	logic [DIST_W:0] sum;

	assign diff = (a >= b) ? (a - b) : (b - a);
	assign sq = diff * diff;
	assign sum = {1'b0, acc_q} + {{(DIST_W+1-2*VAL_W){1'b0}}, sq};
	// saturated value the accumulator takes on a step
	assign acc_next = sum[DIST_W] ? {DIST_W{1'b1}} : sum[DIST_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (clr) begin
			acc_q <= '0;
		end else if (step) begin
			acc_q <= acc_next;
		end
	end

endmodule

[rtl/nndr_table.sv]
// Sorted distance/item table memory, one read and one write port.
// Depends on nndr_pkg.
module nndr_table
	import nndr_pkg::*;
#(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF,
	localparam int AW = $clog2(MAX_ITEMS)
)(
	input  logic clk,
	input  tbl_ctl_t ctl,
	input  logic [AW-1:0] rd_addr,
	input  logic [AW-1:0] wr_addr,
	input  logic [DIST_W-1:0] new_dist,
	input  logic [ITEM_W-1:0] new_item,
	output logic [DIST_W-1:0] rd_dist,
	output logic [ITEM_W-1:0] rd_item
);

	logic [DIST_W+ITEM_W-1:0] mem [MAX_ITEMS];
	logic [DIST_W+ITEM_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= ctl.wr_sel_new ? {new_dist, new_item} : rd_q;
		end
		if (ctl.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_dist = rd_q[DIST_W+ITEM_W-1:ITEM_W];
	assign rd_item = rd_q[ITEM_W-1:0];

endmodule

[rtl/nearest_neighbour_distance_ranker.sv]
// Nearest neighbour distance ranker: brute-force squared Euclidean ranking.
// Query element, clear: accept, query read. Database element: accept, query read, MAC.
// Completing element: MAC, SCAN, SHIFT per entry compared by the insertion sort (the
// shifted ones plus the first one not larger), PLACE, RDONE; MAC to RDONE if the table
// is full. Rank read: accept, query read, RREAD, RDONE. One beat at a time; in_stall is
// high while busy, and a stalled result holds the sequencer in its output state. Async
// reset clears count, accumulator and handshake, not memories or data registers.
module nearest_neighbour_distance_ranker
	import nndr_pkg::*;
#(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
)(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LEN_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  in_beat_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output out_beat_t out_data
);

	localparam int QAW = $clog2(MAX_ELEMENTS);
	localparam int TAW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int LW = $clog2(MAX_ELEMENTS + 1);

	// Configuration registers.
	logic [LEN_W-1:0] vlen_q;
	logic skip_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vlen_q <= VECTOR_LENGTH_RESET;
			skip_q <= 1'b1;
		end else if (cfg_we) begin
			if (cfg_index == REG_VECTOR_LENGTH) vlen_q <= cfg_data;
			if (cfg_index == REG_SKIP_NEAREST) skip_q <= cfg_data[0];
		end
	end

	// Effective length, clamped to 1..MAX_ELEMENTS, minus one = completing index.
	logic [LW-1:0] last_idx;
	always_comb begin
		if (vlen_q == '0) last_idx = '0;
		else if ({19'd0, vlen_q} > MAX_ELEMENTS) last_idx = LW'(MAX_ELEMENTS - 1);
		else last_idx = LW'({19'd0, vlen_q} - 1);
	end

	state_t state_q, state_d;
	in_beat_t beat_q;
	logic [CW-1:0] count_q;
	logic [TAW-1:0] pos_q;
	logic [DIST_W-1:0] dist_q;
	logic [ITEM_W-1:0] item_q;
	logic full_q;
	out_beat_t obuf_q;
	logic ovalid_q;

	// Query store: written and read here in clocked blocks.
	logic [VAL_W-1:0] qmem [MAX_ELEMENTS];
	logic [VAL_W-1:0] qrd_q;
	logic [QAW-1:0] qaddr;
	logic idx_ok;
	assign idx_ok = {20'd0, beat_q.element_index} < MAX_ELEMENTS;
	assign qaddr = QAW'(beat_q.element_index);
	always_ff @(posedge clk) begin
		if (state_q == S_QREAD && beat_q.operation == OP_QUERY && idx_ok)
			qmem[qaddr] <= beat_q.element_value;
		if (state_q == S_QREAD)
			qrd_q <= idx_ok ? qmem[qaddr] : '0;
	end

	// Shared MAC.
	logic mac_clr, mac_step;
	logic [DIST_W-1:0] acc_next;
	nndr_mac u_mac (
		.clk, .arst_n,
		.clr(mac_clr),
		.step(mac_step),
		.a(beat_q.element_value),
		.b(qrd_q),
		.acc_next
	);

	// Table.
	tbl_ctl_t tctl;
	logic [TAW-1:0] rd_addr, wr_addr;
	logic [DIST_W-1:0] rd_dist;
	logic [ITEM_W-1:0] rd_item;
	nndr_table #(.MAX_ITEMS(MAX_ITEMS)) u_tbl (
		.clk, .ctl(tctl),
		.rd_addr, .wr_addr,
		.new_dist(dist_q), .new_item(item_q),
		.rd_dist, .rd_item
	);

	// Effective rank for reads.
	logic [ITEM_W:0] rank_eff;
	logic rank_ok;
	assign rank_eff = {1'b0, beat_q.rank_position} + {{ITEM_W{1'b0}}, skip_q};
	assign rank_ok = (32'(rank_eff) < 32'(count_q)) && (32'(rank_eff) < MAX_ITEMS);

	logic full, done_mac;
	assign full = 32'(count_q) >= MAX_ITEMS;
	assign done_mac = {{(32-IDX_W){1'b0}}, beat_q.element_index} == 32'(last_idx);

	logic out_free;
	assign out_free = !ovalid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_QREAD;
			S_QREAD: begin
				case (beat_q.operation)
					OP_DATABASE: state_d = S_MAC;
					OP_READ: state_d = S_RREAD;
					default: state_d = S_IDLE;
				endcase
			end
			S_MAC: begin
				if (!done_mac) state_d = S_IDLE;
				else if (full) state_d = S_RDONE;
				else if (pos_q == '0) state_d = S_PLACE;
				else state_d = S_SCAN;
			end
			S_SCAN: state_d = S_SHIFT;
			S_SHIFT: begin
				if (rd_dist > dist_q && pos_q != '0) state_d = (pos_q == TAW'(1)) ? S_PLACE : S_SCAN;
				else state_d = S_PLACE;
			end
			S_PLACE: state_d = S_RDONE;
			S_RREAD: state_d = S_RDONE;
			S_RDONE: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		tctl = '0;
		rd_addr = pos_q - TAW'(1);
		wr_addr = pos_q;
		mac_clr = 1'b0;
		mac_step = 1'b0;
		case (state_q)
			S_QREAD: mac_clr = (beat_q.operation == OP_CLEAR);
			S_MAC: mac_step = 1'b1;
			S_SCAN: tctl.rd_en = 1'b1;
			S_SHIFT: tctl.wr_en = (rd_dist > dist_q);
			S_PLACE: begin
				tctl.wr_en = 1'b1;
				tctl.wr_sel_new = 1'b1;
				mac_clr = 1'b1;
			end
			S_RREAD: begin
				tctl.rd_en = 1'b1;
				rd_addr = TAW'(rank_eff);
			end
			S_RDONE: mac_clr = (beat_q.operation == OP_DATABASE);
			default: ;
		endcase
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ovalid_q <= 1'b0;
			pos_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_RDONE && out_free) ovalid_q <= 1'b1;
			else if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
			case (state_q)
				S_QREAD: begin
					if (beat_q.operation == OP_CLEAR) count_q <= '0;
					pos_q <= count_q[TAW-1:0];
				end
				S_SHIFT: if (rd_dist > dist_q && pos_q != '0) pos_q <= pos_q - TAW'(1);
				S_PLACE: count_q <= count_q + CW'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) beat_q <= in_data;
		if (state_q == S_MAC) begin
			dist_q <= acc_next;
			item_q <= ITEM_W'(count_q);
			// table state as the item arrives; the count moves on at placement
			full_q <= full;
		end
		if (state_q == S_SHIFT && !(rd_dist > dist_q && pos_q != '0)) begin
			// pos_q already holds the slot
		end
		if (state_q == S_RDONE && out_free) begin
			if (beat_q.operation == OP_READ) begin
				obuf_q.result_kind <= KIND_RANK;
				obuf_q.item_number <= rank_ok ? rd_item : '0;
				obuf_q.squared_distance <= rank_ok ? rd_dist : '0;
				obuf_q.status <= rank_ok ? ST_OK : ST_RANK_RANGE;
			end else begin
				obuf_q.result_kind <= KIND_ITEM;
				obuf_q.item_number <= full_q ? '0 : item_q;
				obuf_q.squared_distance <= dist_q;
				obuf_q.status <= full_q ? ST_FULL : ST_OK;
			end
		end
	end

	assign out_valid = ovalid_q;
	assign out_data = obuf_q;

endmodule

[rtl/nndr_checker.sv]
// Port-level checker for the ranker, bound to the top level.
// Depends on nndr_pkg.
module nndr_checker
	import nndr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input out_beat_t out_data
);

	// Accepting a beat makes the block busy next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("not busy after accept");

	// Status and kind agree.
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_RANK_RANGE |-> out_data.result_kind == KIND_RANK)
		else $error("range status on item result");

	// Answers with a status other than OK carry item number zero.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.item_number == '0)
		else $error("nonzero item on error");

	// Stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("result dropped");

endmodule

bind nearest_neighbour_distance_ranker nndr_checker u_chk (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);
